// ===== hdl/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg
// shared widths, types and constants for the vector normalizer pipeline
// ----------------------------------------------------------------------------
package vn_pkg;

   localparam int COMP_W    = 32;            // component width
   localparam int MAG_W     = 32;            // magnitude of a component (up to 2^31)
   localparam int SUM_W     = 66;            // sum of three squares
   localparam int ROOT_W    = 33;            // root of the sum
   localparam int ROOT_STEPS = ROOT_W;       // one result bit per stage
   localparam int NUM_W     = MAG_W + 30;    // dividend width: mag << 30
   localparam int QUOT_W    = NUM_W;         // quotient bits produced
   localparam int DIV_STEPS = 32;            // quotient bits beyond 2^31 are never kept
   localparam logic [QUOT_W-1:0] UNIT_ONE = QUOT_W'(64'd1 << 30);

   typedef struct packed {
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
      logic                  zero;
   } vec_meta_type;

endpackage

// ===== hdl/vn_sqrt.sv =====
// ----------------------------------------------------------------------------
// vn_sqrt
// sum of squares followed by a bit-per-stage restoring square root
// ----------------------------------------------------------------------------
module vn_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [vn_pkg::COMP_W-1:0] in_x,
   input  logic signed [vn_pkg::COMP_W-1:0] in_y,
   input  logic signed [vn_pkg::COMP_W-1:0] in_z,
   output logic                          out_valid,
   output vn_pkg::vec_meta_type          out_meta,
   output logic [vn_pkg::ROOT_W-1:0]     out_root
);
   import vn_pkg::*;

   localparam int NS = ROOT_STEPS;
   localparam int SQW = 2*MAG_W;

   // stage a: absolute values
   logic         a_valid_ff;
   vec_meta_type a_meta_ff;
   // stage b: squares
   logic         b_valid_ff;
   vec_meta_type b_meta_ff;
   logic [2:0][SQW-1:0] b_sq_ff;
   // stage c: sum
   logic         c_valid_ff;
   vec_meta_type c_meta_ff;
   logic [SUM_W-1:0] c_sum_ff;
   // root stages
   logic [NS:0]              r_valid_ff;
   vec_meta_type             r_meta_ff [NS+1];
   logic [SUM_W+1:0]         r_rem_ff  [NS+1];
   logic [ROOT_W-1:0]        r_root_ff [NS+1];

   logic [2:0][COMP_W-1:0] comp;
   assign comp[0] = in_x;
   assign comp[1] = in_y;
   assign comp[2] = in_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a_meta_ff.neg[i] <= comp[i][COMP_W-1];
         a_meta_ff.mag[i] <= comp[i][COMP_W-1] ? (~comp[i] + 1'b1) : comp[i];
         b_sq_ff[i]       <= a_meta_ff.mag[i] * a_meta_ff.mag[i];
      end
      a_meta_ff.zero <= (in_x == '0) && (in_y == '0) && (in_z == '0);
      b_meta_ff <= a_meta_ff;
      c_meta_ff <= b_meta_ff;
      c_sum_ff  <= SUM_W'(b_sq_ff[0]) + SUM_W'(b_sq_ff[1]) + SUM_W'(b_sq_ff[2]);
   end

   // stage 0 of the root chain holds the sum as remainder
   always_ff @(posedge clock) begin
      if (reset) r_valid_ff[0] <= 1'b0;
      else       r_valid_ff[0] <= c_valid_ff;
   end
   always_ff @(posedge clock) begin
      r_meta_ff[0] <= c_meta_ff;
      r_rem_ff[0]  <= {2'b00, c_sum_ff};
      r_root_ff[0] <= '0;
   end

   // digit k decides root bit (NS-1-k): compare remainder against (4*root+1) << 2b
   for (genvar k = 0; k < NS; k++) begin : g_root
      localparam int B = NS - 1 - k;
      logic [SUM_W+1:0] trial;
      logic [SUM_W+1:0] root_in;
      logic             fits;
      assign trial = ((SUM_W+2)'({r_root_ff[k], 2'b01})) << (2*B);
      assign fits  = r_rem_ff[k] >= trial;
      assign root_in = '0;
      always_ff @(posedge clock) begin
         if (reset) r_valid_ff[k+1] <= 1'b0;
         else       r_valid_ff[k+1] <= r_valid_ff[k];
      end
      always_ff @(posedge clock) begin
         r_meta_ff[k+1] <= r_meta_ff[k];
         r_rem_ff[k+1]  <= fits ? (r_rem_ff[k] - trial) : (r_rem_ff[k] | root_in);
         r_root_ff[k+1] <= {r_root_ff[k][ROOT_W-2:0], fits};
      end
   end

   assign out_valid = r_valid_ff[NS];
   assign out_meta  = r_meta_ff[NS];
   assign out_root  = r_root_ff[NS];
endmodule

// ===== hdl/vn_div.sv =====
// ----------------------------------------------------------------------------
// vn_div
// three lane restoring divider, one quotient bit per stage, then saturation
// ----------------------------------------------------------------------------
module vn_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  vn_pkg::vec_meta_type      in_meta,
   input  logic [vn_pkg::ROOT_W-1:0] in_root,
   output logic                      out_valid,
   output logic signed [vn_pkg::COMP_W-1:0] out_x,
   output logic signed [vn_pkg::COMP_W-1:0] out_y,
   output logic signed [vn_pkg::COMP_W-1:0] out_z,
   output logic [vn_pkg::MAG_W-1:0]  out_mag,
   output logic                      out_zero
);
   import vn_pkg::*;

   localparam int NS  = DIV_STEPS;
   localparam int RW  = ROOT_W + 1;     // partial remainder width
   localparam int QW  = NS + 1;         // kept quotient bits plus overflow flag

   // quotient = (mag << 30) / root; any bit at or above 2^31 only means "saturate".
   // ovf flags that the true quotient reaches 2^NS, computed at entry.
   logic [NS:0]              v_ff;
   vec_meta_type             m_ff  [NS+1];
   logic [ROOT_W-1:0]        d_ff  [NS+1];
   logic [2:0][RW-1:0]       rem_ff [NS+1];
   logic [2:0][NS-1:0]       q_ff  [NS+1];
   logic [2:0]               ovf_ff [NS+1];

   // bit b of (mag << 30)
   function automatic logic num_bit(input logic [MAG_W-1:0] m, input int b);
      logic [NUM_W-1:0] n;
      n = NUM_W'(m) << 30;
      return n[b];
   endfunction

   // dividend bits: mag << 30, 62 bits; high 30 bits (>= 2^32 quotient range)
   // are handled by comparing (mag << 30) >> NS against root at entry
   logic [2:0][NUM_W-1:0] num;
   always_comb begin
      for (int i = 0; i < 3; i++) num[i] = NUM_W'(in_meta.mag[i]) << 30;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else       v_ff[0] <= in_valid;
   end
   always_ff @(posedge clock) begin
      m_ff[0] <= in_meta;
      d_ff[0] <= in_root;
      for (int i = 0; i < 3; i++) begin
         // high part of the dividend, below 2^30 so fits RW
         ovf_ff[0][i] <= ROOT_W'(num[i] >> NS) >= in_root;
         rem_ff[0][i] <= RW'(num[i] >> NS);
         q_ff[0][i]   <= '0;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_div
      localparam int B = NS - 1 - k;
      logic [2:0][RW:0] shifted;
      logic [2:0]       fits;
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            shifted[i] = {rem_ff[k][i], num_bit(m_ff[k].mag[i], B)};
            fits[i]    = shifted[i] >= (RW+1)'(d_ff[k]);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[k+1] <= 1'b0;
         else       v_ff[k+1] <= v_ff[k];
      end
      always_ff @(posedge clock) begin
         m_ff[k+1]   <= m_ff[k];
         d_ff[k+1]   <= d_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
         for (int i = 0; i < 3; i++) begin
            rem_ff[k+1][i] <= fits[i] ? RW'(shifted[i] - (RW+1)'(d_ff[k]))
                                      : RW'(shifted[i]);
            q_ff[k+1][i]   <= {q_ff[k][i][NS-2:0], fits[i]};
         end
      end
   end

   // output stage: saturate and apply sign
   logic                         o_valid_ff;
   logic [2:0][COMP_W-1:0]       o_unit_ff;
   logic [MAG_W-1:0]             o_mag_ff;
   logic                         o_zero_ff;
   logic [2:0][COMP_W-1:0]       unit_in;
   logic [2:0][QW-1:0]           qs;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qs[i] = (ovf_ff[NS][i] || (QW'(q_ff[NS][i]) > QW'(UNIT_ONE)))
               ? QW'(UNIT_ONE) : QW'(q_ff[NS][i]);
         if (m_ff[NS].zero)        unit_in[i] = '0;
         else if (m_ff[NS].neg[i]) unit_in[i] = COMP_W'(~qs[i] + 1'b1);
         else                      unit_in[i] = COMP_W'(qs[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) o_valid_ff <= 1'b0;
      else       o_valid_ff <= v_ff[NS];
   end
   always_ff @(posedge clock) begin
      o_unit_ff <= unit_in;
      o_mag_ff  <= m_ff[NS].zero ? '0 : MAG_W'(d_ff[NS]);
      o_zero_ff <= m_ff[NS].zero;
   end

   assign out_valid = o_valid_ff;
   assign out_x     = o_unit_ff[0];
   assign out_y     = o_unit_ff[1];
   assign out_z     = o_unit_ff[2];
   assign out_mag   = o_mag_ff;
   assign out_zero  = o_zero_ff;
endmodule

// ===== hdl/vector3_normalise.sv =====
// ----------------------------------------------------------------------------
// vector3_normalise
// length and unit vector of a signed Q16.16 3d vector
// ----------------------------------------------------------------------------
// one vector enters per cycle and busy is always low, so start may be held
// high on every cycle; each result appears on the rsp_ ports marked by
// rsp_valid for one cycle, in order. the path runs through the square root
// (33 stages, one root bit each) and the divider (32 stages, one quotient
// bit each) plus abs, square, sum, entry and output registers. the receiver
// cannot stall; results must be taken as shown
module vector3_normalise (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [vn_pkg::COMP_W-1:0] req_vec_x,
   input  logic signed [vn_pkg::COMP_W-1:0] req_vec_y,
   input  logic signed [vn_pkg::COMP_W-1:0] req_vec_z,
   output logic                             rsp_valid,
   output logic signed [vn_pkg::COMP_W-1:0] rsp_unit_x,
   output logic signed [vn_pkg::COMP_W-1:0] rsp_unit_y,
   output logic signed [vn_pkg::COMP_W-1:0] rsp_unit_z,
   output logic [vn_pkg::MAG_W-1:0]         rsp_magnitude,
   output logic                             rsp_zero_vector
);
   import vn_pkg::*;

   logic              sq_valid;
   vec_meta_type      sq_meta;
   logic [ROOT_W-1:0] sq_root;

   // fully pipelined, never stalls
   assign busy = 1'b0;

   // sum of squares and integer root
   vn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .in_x      (req_vec_x),
      .in_y      (req_vec_y),
      .in_z      (req_vec_z),
      .out_valid (sq_valid),
      .out_meta  (sq_meta),
      .out_root  (sq_root)
   );

   // per-component division by the root, saturation and sign
   vn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_meta   (sq_meta),
      .in_root   (sq_root),
      .out_valid (rsp_valid),
      .out_x     (rsp_unit_x),
      .out_y     (rsp_unit_y),
      .out_z     (rsp_unit_z),
      .out_mag   (rsp_magnitude),
      .out_zero  (rsp_zero_vector)
   );
endmodule

// ===== hdl/vector3_normalise_checker.sv =====
// ----------------------------------------------------------------------------
// vector3_normalise_checker
// port level checks on the normalizer result channel
// ----------------------------------------------------------------------------
module vector3_normalise_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic signed [vn_pkg::COMP_W-1:0] rsp_unit_x,
   input logic [vn_pkg::MAG_W-1:0]         rsp_magnitude,
   input logic                             rsp_zero_vector
);
   import vn_pkg::*;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_zero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |-> rsp_magnitude == '0 && rsp_unit_x == '0)
      else $error("zero vector with nonzero outputs");

   a_nonzero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_vector |-> rsp_magnitude != '0)
      else $error("nonzero vector with zero length");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unit_x <= 32'sd1073741824) && (rsp_unit_x >= -32'sd1073741824))
      else $error("unit component out of range");
endmodule

bind vector3_normalise vector3_normalise_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_unit_x      (rsp_unit_x),
   .rsp_magnitude   (rsp_magnitude),
   .rsp_zero_vector (rsp_zero_vector)
);
